>>> rtl/power_key_press_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// power key press classifier assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef POWER_KEY_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define POWER_KEY_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PKPC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pkpc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PKPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pkpc: next-cycle check failed");

`endif

>>> rtl/pkpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkpc_pkg
// types, codes and reset values for the power key press classifier
// ----------------------------------------------------------------------------
package pkpc_pkg;

  // field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned PmW     = 2;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // default timer width
  localparam int unsigned TIMER_WIDTH_DEF = 16;

  // register reset values
  localparam logic [CfgW-1:0] WAIT_ON_RST   = 16'd250;
  localparam logic [CfgW-1:0] WAIT_OFF_RST  = 16'd400;
  localparam logic [CfgW-1:0] LONG_WAIT_RST = 16'd700;

  // display states at or above this count as display off
  localparam logic [PmW-1:0] PM_OFF = 2'd2;

  // event codes
  typedef enum logic [CmdW-1:0] {
    CMD_TICK          = 3'd0,
    CMD_POWER_PRESS   = 3'd1,
    CMD_POWER_RELEASE = 3'd2,
    CMD_CANCEL_PRESS  = 3'd3,
    CMD_CANCEL_RELEASE = 3'd4
  } cmd_e;

  // action codes
  typedef enum logic [ActionW-1:0] {
    ACT_NONE        = 2'd0,
    ACT_DISPLAY_OFF = 2'd1,
    ACT_HOME        = 2'd2,
    ACT_POWEROFF    = 2'd3
  } action_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WAIT_DISPLAY_ON  = 2'd0,
    REG_WAIT_DISPLAY_OFF = 2'd1,
    REG_LONG_PRESS_WAIT  = 2'd2
  } cfg_reg_e;

endpackage

>>> rtl/pkpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkpc channel interfaces
// event input, action output and register write channels
// ----------------------------------------------------------------------------

// event input channel
interface pkpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [pkpc_pkg::CmdW-1:0]      cmd;
  logic [pkpc_pkg::PmW-1:0]       pm_level;
  logic                           key_locked;
  logic                           call_active;
  logic                           idle_locked;
  logic                           remote_locked;

  modport source (output valid, cmd, pm_level, key_locked, call_active, idle_locked,
                  remote_locked, input ready);
  modport sink   (input valid, cmd, pm_level, key_locked, call_active, idle_locked,
                  remote_locked, output ready);
endinterface

// action output channel
interface pkpc_out_if;
  logic                           valid;
  logic                           ready;
  logic [pkpc_pkg::ActionW-1:0]   action;

  modport source (output valid, action, input ready);
  modport sink   (input valid, action, output ready);
endinterface

// register write channel
interface pkpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pkpc_pkg::CfgIdxW-1:0]   index;
  logic [pkpc_pkg::CfgW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/power_key_press_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_key_press_classifier_top
// classifies power key events and ticks into display, home and power-off actions
// ----------------------------------------------------------------------------
// Each accepted event yields exactly one action, presented from the output
// register in the cycle after the transfer. One event can be taken every cycle:
// the flag and timer updates and the action decision sit in one short stage
// between the input handshake and the action register, and input ready only
// drops while a finished action waits in that register with ready low.
// Register writes are always ready and take effect in the next cycle.
// ----------------------------------------------------------------------------
`include "power_key_press_classifier_top_assert.svh"

module power_key_press_classifier_top #(
  parameter int unsigned TIMER_WIDTH = pkpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pkpc_in_if.sink          in_i,
  pkpc_out_if.source       out_o,
  pkpc_cfg_if.sink         cfg_i
);

  localparam logic [32:0] TimerMax = (33'd1 << TIMER_WIDTH) - 33'd1;

  // saturating timer load, zero behaves as one
  function automatic logic [TIMER_WIDTH-1:0] timer_load(
    input logic [pkpc_pkg::CfgW-1:0] v
  );
    logic [32:0] w;
    w = 33'(v);
    if (w == 33'd0) begin
      w = 33'd1;
    end
    if (w > TimerMax) begin
      w = TimerMax;
    end
    return w[TIMER_WIDTH-1:0];
  endfunction

  logic [pkpc_pkg::CfgW-1:0] wait_on_q, wait_off_q, long_wait_q;

  logic [TIMER_WIDTH-1:0] decision_left_q, decision_left_d;
  logic [TIMER_WIDTH-1:0] hold_left_q, hold_left_d;
  logic decision_running_q, decision_running_d;
  logic hold_running_q, hold_running_d;
  logic display_was_on_q, display_was_on_d;
  logic long_seen_q, long_seen_d;
  logic press_odd_q, press_odd_d;
  logic cancel_held_q, cancel_held_d;

  logic                         out_valid_q;
  pkpc_pkg::action_e            action_q, action_d;
  logic                         in_xfer;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_on_q   <= pkpc_pkg::WAIT_ON_RST;
      wait_off_q  <= pkpc_pkg::WAIT_OFF_RST;
      long_wait_q <= pkpc_pkg::LONG_WAIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pkpc_pkg::REG_WAIT_DISPLAY_ON:  wait_on_q   <= cfg_i.data;
        pkpc_pkg::REG_WAIT_DISPLAY_OFF: wait_off_q  <= cfg_i.data;
        pkpc_pkg::REG_LONG_PRESS_WAIT:  long_wait_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // handshake: the action register frees up when it is empty or being taken
  assign in_i.ready   = !out_valid_q || out_o.ready;
  assign in_xfer      = in_i.valid && in_i.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.action = action_q;

  // next state and action for one event
  always_comb begin
    decision_left_d    = decision_left_q;
    decision_running_d = decision_running_q;
    hold_left_d        = hold_left_q;
    hold_running_d     = hold_running_q;
    display_was_on_d   = display_was_on_q;
    long_seen_d        = long_seen_q;
    press_odd_d        = press_odd_q;
    cancel_held_d      = cancel_held_q;
    action_d           = pkpc_pkg::ACT_NONE;

    unique case (in_i.cmd)
      pkpc_pkg::CMD_TICK: begin
        // hold timer goes first
        if (hold_running_q) begin
          if (hold_left_q <= TIMER_WIDTH'(1)) begin
            hold_left_d    = '0;
            hold_running_d = 1'b0;
            long_seen_d    = 1'b1;
            press_odd_d    = 1'b0;
            if (!in_i.remote_locked) begin
              decision_running_d = 1'b0;
              decision_left_d    = '0;
              action_d           = pkpc_pkg::ACT_POWEROFF;
            end
          end else begin
            hold_left_d = hold_left_q - TIMER_WIDTH'(1);
          end
        end
        // decision timer, unless cancelled by power-off
        if (decision_running_d) begin
          if (decision_left_d <= TIMER_WIDTH'(1)) begin
            decision_left_d    = '0;
            decision_running_d = 1'b0;
            if (in_i.key_locked) begin
              press_odd_d = 1'b0;
              action_d    = display_was_on_q ? pkpc_pkg::ACT_DISPLAY_OFF
                                             : pkpc_pkg::ACT_NONE;
            end else if (!press_odd_d) begin
              // double press
              action_d = pkpc_pkg::ACT_NONE;
            end else begin
              press_odd_d = 1'b0;
              if (!display_was_on_q || in_i.pm_level >= pkpc_pkg::PM_OFF) begin
                action_d = pkpc_pkg::ACT_NONE;
              end else if (in_i.call_active || in_i.idle_locked ||
                           in_i.remote_locked) begin
                action_d = pkpc_pkg::ACT_DISPLAY_OFF;
              end else begin
                action_d = pkpc_pkg::ACT_HOME;
              end
            end
          end else begin
            decision_left_d = decision_left_d - TIMER_WIDTH'(1);
          end
        end
      end
      pkpc_pkg::CMD_POWER_PRESS: begin
        display_was_on_d   = (in_i.pm_level < pkpc_pkg::PM_OFF);
        press_odd_d        = !press_odd_q;
        decision_running_d = 1'b0;
        decision_left_d    = '0;
        long_seen_d        = 1'b0;
        hold_running_d     = 1'b1;
        hold_left_d        = timer_load(long_wait_q);
      end
      pkpc_pkg::CMD_POWER_RELEASE: begin
        hold_running_d     = 1'b0;
        hold_left_d        = '0;
        decision_running_d = 1'b0;
        decision_left_d    = '0;
        priority if (cancel_held_q) begin
          cancel_held_d = 1'b0;
          press_odd_d   = 1'b0;
        end else if (long_seen_q) begin
          long_seen_d = 1'b0;
        end else begin
          decision_running_d = 1'b1;
          decision_left_d    = timer_load(display_was_on_q ? wait_on_q : wait_off_q);
        end
      end
      pkpc_pkg::CMD_CANCEL_PRESS:   cancel_held_d = 1'b1;
      pkpc_pkg::CMD_CANCEL_RELEASE: cancel_held_d = 1'b0;
      default: ;
    endcase
  end

  // state flags and timers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decision_left_q    <= '0;
      decision_running_q <= 1'b0;
      hold_left_q        <= '0;
      hold_running_q     <= 1'b0;
      display_was_on_q   <= 1'b0;
      long_seen_q        <= 1'b0;
      press_odd_q        <= 1'b0;
      cancel_held_q      <= 1'b0;
    end else if (in_xfer) begin
      decision_left_q    <= decision_left_d;
      decision_running_q <= decision_running_d;
      hold_left_q        <= hold_left_d;
      hold_running_q     <= hold_running_d;
      display_was_on_q   <= display_was_on_d;
      long_seen_q        <= long_seen_d;
      press_odd_q        <= press_odd_d;
      cancel_held_q      <= cancel_held_d;
    end
  end

  // action register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // action register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= action_d;
    end
  end

  // checks on timer and output bookkeeping
  `PKPC_ASSERT_SAME(a_hold_nonzero, clk_i, rst_ni, hold_running_q, hold_left_q != '0)
  `PKPC_ASSERT_SAME(a_decision_nonzero, clk_i, rst_ni, decision_running_q,
                    decision_left_q != '0)
  `PKPC_ASSERT_NEXT(a_poweroff_cancels, clk_i, rst_ni,
                    in_xfer && action_d == pkpc_pkg::ACT_POWEROFF,
                    !decision_running_q && !hold_running_q && out_valid_q)
  `PKPC_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, in_i.ready)

endmodule

>>> tb/sv/tb_power_key_press_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_key_press_classifier_top
// sends key events and ticks through the classifier with random idling on
// both channels, predicts every action with its own timer model and checks
// each action transfer in order against it
// ----------------------------------------------------------------------------
module tb_power_key_press_classifier_top;

  localparam int unsigned TimerW = pkpc_pkg::TIMER_WIDTH_DEF;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainLimit = 2000;
  localparam logic [pkpc_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam logic [pkpc_pkg::CmdW-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [pkpc_pkg::CmdW-1:0] CMD_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [pkpc_pkg::CmdW-1:0] cmd;
    logic [pkpc_pkg::PmW-1:0]  pm_level;
    logic                      key_locked;
    logic                      call_active;
    logic                      idle_locked;
    logic                      remote_locked;
  } key_event_t;

  logic clk_i;
  logic rst_ni;

  pkpc_in_if  in_if ();
  pkpc_out_if out_if ();
  pkpc_cfg_if cfg_if ();

  power_key_press_classifier_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // events waiting to be offered, and actions predicted for accepted events
  key_event_t          event_q[$];
  pkpc_pkg::action_e   action_q[$];
  int unsigned fault_cnt = 0;

  // idling control
  logic        jitter_on = 1'b1;
  logic        stall_armed = 1'b0;
  logic        hold_off;
  int unsigned in_gap = 0, in_calm = 0;
  int unsigned out_gap = 0, out_calm = 0;
  logic        in_fired = 1'b0;
  logic        out_fired = 1'b0;

  // timing registers as the block should hold them
  logic [pkpc_pkg::CfgW-1:0] wait_on_r = pkpc_pkg::WAIT_ON_RST;
  logic [pkpc_pkg::CfgW-1:0] wait_off_r = pkpc_pkg::WAIT_OFF_RST;
  logic [pkpc_pkg::CfgW-1:0] long_wait_r = pkpc_pkg::LONG_WAIT_RST;

  // classifier state
  logic [TimerW-1:0] decide_cnt = '0;
  logic              decide_run = 1'b0;
  logic [TimerW-1:0] hold_cnt = '0;
  logic              hold_run = 1'b0;
  logic              disp_lit = 1'b0;
  logic              long_hit = 1'b0;
  logic              odd_press = 1'b0;
  logic              cancel_down = 1'b0;

  // zero loads as one tick, oversize loads saturate
  function automatic logic [TimerW-1:0] load_timer(logic [pkpc_pkg::CfgW-1:0] ticks);
    longint unsigned v;
    longint unsigned top;
    v = (ticks == '0) ? 64'd1 : 64'(ticks);
    top = (64'd1 << TimerW) - 64'd1;
    if (v > top) v = top;
    return v[TimerW-1:0];
  endfunction

  // advance the state by one event and return the action it causes
  function automatic pkpc_pkg::action_e classify_event(key_event_t ev);
    pkpc_pkg::action_e act;
    act = pkpc_pkg::ACT_NONE;
    case (ev.cmd)
      pkpc_pkg::CMD_TICK: begin
        // hold timer first, a power-off cancels the decision
        if (hold_run) begin
          if (hold_cnt <= 1) begin
            hold_cnt = '0;
            hold_run = 1'b0;
            long_hit = 1'b1;
            odd_press = 1'b0;
            if (!ev.remote_locked) begin
              decide_run = 1'b0;
              decide_cnt = '0;
              act = pkpc_pkg::ACT_POWEROFF;
            end
          end else begin
            hold_cnt = hold_cnt - 1'b1;
          end
        end
        if (decide_run) begin
          if (decide_cnt <= 1) begin
            decide_cnt = '0;
            decide_run = 1'b0;
            if (ev.key_locked) begin
              odd_press = 1'b0;
              act = disp_lit ? pkpc_pkg::ACT_DISPLAY_OFF : pkpc_pkg::ACT_NONE;
            end else if (!odd_press) begin
              // second press of a double press
              act = pkpc_pkg::ACT_NONE;
            end else begin
              odd_press = 1'b0;
              if (!disp_lit || ev.pm_level >= pkpc_pkg::PM_OFF) act = pkpc_pkg::ACT_NONE;
              else if (ev.call_active || ev.idle_locked || ev.remote_locked)
                act = pkpc_pkg::ACT_DISPLAY_OFF;
              else act = pkpc_pkg::ACT_HOME;
            end
          end else begin
            decide_cnt = decide_cnt - 1'b1;
          end
        end
      end
      pkpc_pkg::CMD_POWER_PRESS: begin
        disp_lit = (ev.pm_level < pkpc_pkg::PM_OFF);
        odd_press = !odd_press;
        decide_run = 1'b0;
        decide_cnt = '0;
        long_hit = 1'b0;
        hold_run = 1'b1;
        hold_cnt = load_timer(long_wait_r);
      end
      pkpc_pkg::CMD_POWER_RELEASE: begin
        hold_run = 1'b0;
        hold_cnt = '0;
        decide_run = 1'b0;
        decide_cnt = '0;
        if (cancel_down) begin
          cancel_down = 1'b0;
          odd_press = 1'b0;
        end else if (long_hit) begin
          long_hit = 1'b0;
        end else begin
          decide_run = 1'b1;
          decide_cnt = load_timer(disp_lit ? wait_on_r : wait_off_r);
        end
      end
      pkpc_pkg::CMD_CANCEL_PRESS: cancel_down = 1'b1;
      pkpc_pkg::CMD_CANCEL_RELEASE: cancel_down = 1'b0;
      default: begin
      end
    endcase
    return act;
  endfunction

  task automatic report_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= MaxReports) $display("%0t: %s", $time, msg);
  endtask

  // idle cycles before the next transfer, with occasional stretches of none
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (!jitter_on) return 0;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // event driver
  always @(negedge clk_i) begin : event_drive
    key_event_t ev;
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.cmd           <= pkpc_pkg::CMD_TICK;
      in_if.pm_level      <= '0;
      in_if.key_locked    <= 1'b0;
      in_if.call_active   <= 1'b0;
      in_if.idle_locked   <= 1'b0;
      in_if.remote_locked <= 1'b0;
    end else if (in_if.valid && !in_fired) begin
      // hold the offered event until its transfer
    end else if (in_gap != 0) begin
      in_if.valid <= 1'b0;
      in_gap--;
    end else if (event_q.size() != 0) begin
      ev = event_q.pop_front();
      in_if.cmd           <= ev.cmd;
      in_if.pm_level      <= ev.pm_level;
      in_if.key_locked    <= ev.key_locked;
      in_if.call_active   <= ev.call_active;
      in_if.idle_locked   <= ev.idle_locked;
      in_if.remote_locked <= ev.remote_locked;
      in_if.valid         <= 1'b1;
      in_gap = draw_gap(in_calm);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // event monitor, predicts the action of each accepted event
  always @(posedge clk_i) begin : event_watch
    key_event_t ev;
    in_fired <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      ev = {in_if.cmd, in_if.pm_level, in_if.key_locked, in_if.call_active,
            in_if.idle_locked, in_if.remote_locked};
      action_q.push_back(classify_event(ev));
    end
  end

  // action receiver
  always @(negedge clk_i) begin : action_drive
    if (!rst_ni || hold_off) begin
      out_if.ready <= 1'b0;
    end else if (out_if.ready && !out_fired) begin
      // keep waiting for the next action
    end else if (out_gap != 0) begin
      out_if.ready <= 1'b0;
      out_gap--;
    end else begin
      out_if.ready <= 1'b1;
      out_gap = draw_gap(out_calm);
    end
  end

  // action checker
  always @(posedge clk_i) begin : action_check
    pkpc_pkg::action_e want;
    out_fired <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (action_q.size() == 0) begin
        report_fault($sformatf("action %0d with no event waiting", out_if.action));
      end else begin
        want = action_q.pop_front();
        if (out_if.action !== want)
          report_fault($sformatf("action mismatch: expected %0d, actual %0d",
                                 want, out_if.action));
      end
    end
  end

  // long receiver hold-off so that the block stalls its input
  initial begin : receiver_stall
    hold_off = 1'b0;
    wait (stall_armed);
    repeat ($urandom_range(5, 40)) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog
  initial begin : watchdog
    #(10_000_000);
    $display("simulation failed");
    $finish;
  end

  task automatic queue_event(logic [pkpc_pkg::CmdW-1:0] cmd, logic [pkpc_pkg::PmW-1:0] pm,
                             logic kl, logic call, logic idle, logic rl);
    key_event_t ev;
    ev = {cmd, pm, kl, call, idle, rl};
    event_q.push_back(ev);
  endtask

  // event with random status, key lock kept rare
  task automatic queue_cmd(logic [pkpc_pkg::CmdW-1:0] cmd);
    queue_event(cmd, pkpc_pkg::PmW'($urandom_range(0, 3)), $urandom_range(0, 7) == 0,
                $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0);
  endtask

  task automatic queue_ticks(int unsigned n);
    repeat (n) queue_cmd(pkpc_pkg::CMD_TICK);
  endtask

  // press and release with random hold and follow-up, sometimes double or cancelled
  task automatic queue_press_cycle();
    logic        cancel;
    int unsigned settle;
    cancel = ($urandom_range(0, 7) == 0);
    settle = 32'((wait_on_r > wait_off_r) ? wait_on_r : wait_off_r);
    if (cancel) queue_cmd(pkpc_pkg::CMD_CANCEL_PRESS);
    queue_cmd(pkpc_pkg::CMD_POWER_PRESS);
    queue_ticks($urandom_range(0, long_wait_r + 2));
    queue_cmd(pkpc_pkg::CMD_POWER_RELEASE);
    if (cancel && $urandom_range(0, 1) == 0) queue_cmd(pkpc_pkg::CMD_CANCEL_RELEASE);
    if ($urandom_range(0, 3) == 0) begin
      queue_ticks($urandom_range(0, wait_on_r));
      queue_cmd(pkpc_pkg::CMD_POWER_PRESS);
      queue_ticks($urandom_range(0, 2));
      queue_cmd(pkpc_pkg::CMD_POWER_RELEASE);
    end
    queue_ticks($urandom_range(0, settle + 2));
  endtask

  task automatic queue_random(int unsigned n_events);
    while (event_q.size() < n_events) begin
      if ($urandom_range(0, 9) < 8) queue_press_cycle();
      else repeat ($urandom_range(1, 4)) queue_cmd(pkpc_pkg::CmdW'($urandom_range(0, 7)));
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (event_q.size() != 0 || in_if.valid || action_q.size() != 0);
  endtask

  task automatic write_reg(logic [pkpc_pkg::CfgIdxW-1:0] idx, logic [pkpc_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    case (idx)
      pkpc_pkg::REG_WAIT_DISPLAY_ON:  wait_on_r = val;
      pkpc_pkg::REG_WAIT_DISPLAY_OFF: wait_off_r = val;
      pkpc_pkg::REG_LONG_PRESS_WAIT:  long_wait_r = val;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_timing(logic [pkpc_pkg::CfgW-1:0] on_ticks,
                            logic [pkpc_pkg::CfgW-1:0] off_ticks,
                            logic [pkpc_pkg::CfgW-1:0] long_ticks);
    write_reg(pkpc_pkg::REG_WAIT_DISPLAY_ON, on_ticks);
    write_reg(pkpc_pkg::REG_WAIT_DISPLAY_OFF, off_ticks);
    write_reg(pkpc_pkg::REG_LONG_PRESS_WAIT, long_ticks);
  endtask

  // stimulus
  initial begin : stimulus
    int          c;
    int unsigned drain;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = pkpc_pkg::REG_WAIT_DISPLAY_ON;
    cfg_if.data         = '0;
    rst_ni              = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset timing: a full decision delay with display on launches home
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 0, 0, 0, 0, 0);
    queue_ticks(pkpc_pkg::WAIT_ON_RST - 1);
    queue_event(pkpc_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    wait_idle();

    // directed cases, zero delay loads as one tick
    set_timing('0, 16'd1, 16'd3);
    write_reg(REG_SPARE, '1);
    // unused codes with every status bit set
    for (c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      queue_event(c[pkpc_pkg::CmdW-1:0], 3, 1, 1, 1, 1);
    // single press with display on launches home
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    // call in progress turns the display off
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 1, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 1, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 1, 0, 1, 0, 0);
    // display already off at the press
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 2, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 2, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    // double press
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    // long press requests power-off, the release then decides nothing
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 0, 0, 0, 0, 0);
    // cancel key held over the press
    queue_event(pkpc_pkg::CMD_CANCEL_PRESS, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 0, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_CANCEL_RELEASE, 0, 0, 0, 0, 0);
    // key lock with display on
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 1, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 1, 0, 0, 0, 0);
    queue_event(pkpc_pkg::CMD_TICK, 0, 1, 0, 0, 0);
    wait_idle();

    // random phases over several timings, the second one with a receiver stall
    for (c = 0; c < 4; c++) begin
      case (c)
        0: set_timing(16'd1, 16'd1, 16'd1);
        1: set_timing('0, 16'd5, 16'd2);
        default: set_timing(pkpc_pkg::CfgW'($urandom_range(1, 12)),
                            pkpc_pkg::CfgW'($urandom_range(1, 12)),
                            pkpc_pkg::CfgW'($urandom_range(1, 8)));
      endcase
      queue_random(170);
      if (c == 1) stall_armed = 1'b1;
      wait_idle();
    end

    // largest timer values, short press bursts with no idling
    set_timing('1, '1, '1);
    jitter_on = 1'b0;
    queue_event(pkpc_pkg::CMD_POWER_PRESS, 0, 0, 0, 0, 0);
    queue_ticks(4);
    queue_event(pkpc_pkg::CMD_POWER_RELEASE, 0, 0, 0, 0, 0);
    queue_ticks(4);

    // all events accepted, then outstanding actions with a bound
    do @(posedge clk_i);
    while (event_q.size() != 0 || in_if.valid);
    drain = 0;
    while (action_q.size() != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (action_q.size() != 0)
      report_fault($sformatf("%0d actions never arrived", action_q.size()));
    if (fault_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
